>>> rtl/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants of the motor command framer.
// ----------------------------------------------------------------------------
package mcf_pkg;

    localparam int FRAME_BYTES = 22;
    localparam int TEXT_BYTES  = 22;
    localparam int BIN_BYTES   = 10;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int MOTORS      = 4;

    localparam logic signed [15:0] TEXT_LIMIT = 16'sd100;
    localparam logic signed [15:0] BIN_MIN    = -16'sd32768;
    localparam logic signed [15:0] BIN_CLAMP  = -16'sd32767;

    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic {
        OP_MOVE = 1'b0,
        OP_STOP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_BINARY_MODE = 2'd0,
        REG_HEADER_BYTE = 2'd1,
        REG_FOOTER_BYTE = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
        logic signed [15:0] speed_three;
        logic signed [15:0] speed_four;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } t_res;

    typedef struct packed {
        logic       binary_mode;
        logic [7:0] header_byte;
        logic [7:0] footer_byte;
    } t_cfg;

    typedef logic [FRAME_BYTES-1:0][7:0] t_bytes;

    typedef struct packed {
        t_bytes bytes;
        t_idx   last;
    } t_frame;

endpackage

>>> rtl/motor_command_framer_top.sv
// ----------------------------------------------------------------------------
// motor_command_framer_top
// Turns motor speed commands into serial text or binary byte frames.
// ----------------------------------------------------------------------------
// A command is captured in an input register, formatted in one pass into a
// frame register, and sent one byte per cycle while i_ready is high: a text or
// stop frame has 22 bytes, a binary frame 10. The next command is taken while
// a frame is being sent; if it already waits in the input register, its first
// byte follows the previous frame's last byte with no gap. The frame register
// loads when the previous frame is done. frame_end marks the last byte.
// Registers at byte addresses 0 (binary_mode), 4 (header_byte) and 8 (footer_byte)
// must be written by the user only while the block is idle; the block does not enforce it.
module motor_command_framer_top
    import mcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg   r_cfg;
    t_cmd   r_cmd;
    logic   r_cmd_vld;
    t_bytes r_frame;
    t_idx   r_last;
    t_idx   r_idx;
    logic   r_busy;

    t_frame w_frame;
    t_reg   w_reg;
    logic   w_wr;
    logic   w_out_fire;
    logic   w_frame_done;
    logic   w_load;

    // configuration port
    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_BINARY_MODE: r_cfg.binary_mode <= pwdata[0];
                REG_HEADER_BYTE: r_cfg.header_byte <= pwdata[7:0];
                REG_FOOTER_BYTE: r_cfg.footer_byte <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_BINARY_MODE: prdata = {31'b0, r_cfg.binary_mode};
            REG_HEADER_BYTE: prdata = {24'b0, r_cfg.header_byte};
            REG_FOOTER_BYTE: prdata = {24'b0, r_cfg.footer_byte};
            default:         prdata = '0;
        endcase
    end

    // handshake control
    assign w_out_fire   = r_busy && i_ready;
    assign w_frame_done = w_out_fire && (r_idx == r_last);
    assign w_load       = r_cmd_vld && (!r_busy || w_frame_done);
    assign o_ready      = !r_cmd_vld || w_load;

    mcf_format u_format (
        .i_cmd   (r_cmd),
        .i_cfg   (r_cfg),
        .o_frame (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_busy    <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_cmd_vld <= 1'b1;
            end else if (w_load) begin
                r_cmd_vld <= 1'b0;
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_frame_done) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else if (w_out_fire) begin
                r_idx <= r_idx + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_frame <= w_frame.bytes;
            r_last  <= w_frame.last;
        end
    end

    assign o_valid         = r_busy;
    assign o_res.out_byte  = r_frame[r_idx];
    assign o_res.frame_end = (r_idx == r_last);

    // byte pointer never runs past the end of the frame in flight
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last))
        else $error("byte index beyond frame end");

    // only the two frame lengths exist
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_last == t_idx'(TEXT_BYTES - 1) || r_last == t_idx'(BIN_BYTES - 1)))
        else $error("bad frame length");

    // a new frame always starts at its first byte
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_busy && r_idx == '0))
        else $error("frame did not start at first byte");

    // a stalled output keeps its byte position
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_busy && $stable(r_idx)))
        else $error("byte position moved during stall");

endmodule

>>> rtl/mcf_format.sv
// ----------------------------------------------------------------------------
// mcf_format
// Builds the whole byte frame of one command: text, binary or stop frame.
// ----------------------------------------------------------------------------
module mcf_format
    import mcf_pkg::*;
(
    input  t_cmd   i_cmd,
    input  t_cfg   i_cfg,
    output t_frame o_frame
);

    logic signed [15:0] w_spd [MOTORS];
    logic               w_stop;

    assign w_spd[0] = i_cmd.speed_one;
    assign w_spd[1] = i_cmd.speed_two;
    assign w_spd[2] = i_cmd.speed_three;
    assign w_spd[3] = i_cmd.speed_four;
    assign w_stop   = (i_cmd.opcode == OP_STOP);

    always_comb begin
        logic signed [15:0] s_neg;
        logic signed [15:0] s_bin;
        logic [6:0]         mag;
        logic [14:0]        prod;
        logic [3:0]         hund;
        logic [3:0]         tens;
        logic [6:0]         rem;
        logic               neg;

        o_frame = '0;
        s_neg   = '0;
        s_bin   = '0;
        mag     = '0;
        prod    = '0;
        hund    = '0;
        tens    = '0;
        rem     = '0;
        neg     = 1'b0;

        if (!w_stop && i_cfg.binary_mode) begin
            o_frame.bytes[0] = i_cfg.header_byte;
            for (int m = 0; m < MOTORS; m++) begin
                s_bin = (w_spd[m] == BIN_MIN) ? BIN_CLAMP : w_spd[m];
                o_frame.bytes[1 + 2*m] = s_bin[7:0];
                o_frame.bytes[2 + 2*m] = s_bin[15:8];
            end
            o_frame.bytes[BIN_BYTES-1] = i_cfg.footer_byte;
            o_frame.last = t_idx'(BIN_BYTES - 1);
        end else begin
            for (int m = 0; m < MOTORS; m++) begin
                s_neg = -w_spd[m];
                priority if (w_stop) begin
                    neg = 1'b1;
                    mag = '0;
                end else if (w_spd[m] > TEXT_LIMIT) begin
                    neg = 1'b0;
                    mag = TEXT_LIMIT[6:0];
                end else if (w_spd[m] < -TEXT_LIMIT) begin
                    neg = 1'b1;
                    mag = TEXT_LIMIT[6:0];
                end else if (w_spd[m][15]) begin
                    neg = 1'b1;
                    mag = s_neg[6:0];
                end else begin
                    neg = 1'b0;
                    mag = w_spd[m][6:0];
                end
                // divide by ten: x*205 >> 11 is exact below 1029
                prod = 15'(mag) * 15'd205;
                if (mag == TEXT_LIMIT[6:0]) begin
                    hund = 4'd1;
                    tens = 4'd0;
                    rem  = 7'd0;
                end else begin
                    hund = 4'd0;
                    tens = prod[14:11];
                    rem  = mag - (7'(tens) << 3) - (7'(tens) << 1);
                end
                o_frame.bytes[5*m]     = CHAR_ONE + 8'(m);
                o_frame.bytes[5*m + 1] = neg ? CHAR_R : CHAR_F;
                o_frame.bytes[5*m + 2] = CHAR_ZERO + 8'(hund);
                o_frame.bytes[5*m + 3] = CHAR_ZERO + 8'(tens);
                o_frame.bytes[5*m + 4] = CHAR_ZERO + 8'(rem[3:0]);
            end
            o_frame.bytes[TEXT_BYTES-2] = CHAR_CR;
            o_frame.bytes[TEXT_BYTES-1] = CHAR_LF;
            o_frame.last = t_idx'(TEXT_BYTES - 1);
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor command framer.
// Commands go in over valid/ready, frame bytes come back over valid/ready and
// are matched one by one against a frame predictor kept in the bench. A short
// list of hand-written commands comes first, then random commands in several
// register settings, with both sides stalling at random in most phases.
// ----------------------------------------------------------------------------
module tb;
    import mcf_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 6;
    localparam int PHASE_CMDS  = 55;
    localparam logic [175:0] STOP_TXT = "1R0002R0003R0004R000\015\012";

    typedef struct packed {
        logic         binary;
        logic [7:0]   header;
        logic [7:0]   footer;
        t_cmd         cmd;
        logic [175:0] text;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_cmd        i_cmd;
    logic        o_valid;
    logic        i_ready;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_res      frame_bytes_due[$];
    t_res      due_byte;
    t_cfg      cfg_shadow;
    t_step_row step_rows[$];
    int        fail_cnt    = 0;
    int        idle_cycles = 0;
    int        snd_idle    = 0;
    int        rcv_idle    = 0;

    motor_command_framer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic int clamp_speed(input int v, input int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // queues the bytes of the frame the block should send for this command
    task automatic expect_frame(input t_cmd c, input logic [175:0] typed);
        logic [7:0]         fb [22];
        logic signed [15:0] sp [4];
        logic [15:0]        w;
        int                 n;
        int                 s;
        int                 mag;
        t_res               r;
        n = 0;
        sp[0] = c.speed_one;
        sp[1] = c.speed_two;
        sp[2] = c.speed_three;
        sp[3] = c.speed_four;
        if (typed == '0 && c.opcode == OP_STOP) typed = STOP_TXT;
        if (typed != '0) begin
            for (int i = 0; i < 22; i++) fb[i] = typed[(21 - i) * 8 +: 8];
            n = 22;
        end else if (!cfg_shadow.binary_mode) begin
            for (int m = 0; m < 4; m++) begin
                s = clamp_speed(sp[m], 100);
                mag = (s < 0) ? -s : s;
                fb[n]     = 8'("1" + m);
                fb[n + 1] = (s < 0) ? "R" : "F";
                fb[n + 2] = 8'("0" + mag / 100);
                fb[n + 3] = 8'("0" + (mag / 10) % 10);
                fb[n + 4] = 8'("0" + mag % 10);
                n += 5;
            end
            fb[n]     = 8'h0d;
            fb[n + 1] = 8'h0a;
            n += 2;
        end else begin
            fb[0] = cfg_shadow.header_byte;
            n = 1;
            for (int m = 0; m < 4; m++) begin
                s = clamp_speed(sp[m], 32767);
                w = 16'(s);
                fb[n]     = w[7:0];
                fb[n + 1] = w[15:8];
                n += 2;
            end
            fb[n] = cfg_shadow.footer_byte;
            n++;
        end
        for (int i = 0; i < n; i++) begin
            r.out_byte  = fb[i];
            r.frame_end = (i == n - 1);
            frame_bytes_due.push_back(r);
        end
    endtask

    task automatic cfg_write(input t_reg idx, input logic [31:0] val);
        logic [31:0] rd_want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_BINARY_MODE: cfg_shadow.binary_mode = val[0];
            REG_HEADER_BYTE: cfg_shadow.header_byte = val[7:0];
            REG_FOOTER_BYTE: cfg_shadow.footer_byte = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        // read back the register just written
        case (idx)
            REG_BINARY_MODE: rd_want = {31'd0, cfg_shadow.binary_mode};
            REG_HEADER_BYTE: rd_want = {24'd0, cfg_shadow.header_byte};
            REG_FOOTER_BYTE: rd_want = {24'd0, cfg_shadow.footer_byte};
            default:         rd_want = '0;
        endcase
        if (prdata !== rd_want)
            report_mismatch($sformatf("reg %0d reads %h, want %h", idx, prdata, rd_want));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // holds off new commands until every pending frame byte has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_cmd(input t_cmd c, input logic [175:0] typed);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expect_frame(c, typed);
    endtask

    function automatic logic [15:0] rand_speed();
        int r;
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'h7fff : 16'h7ffe;
            1: return $urandom_range(1) ? 16'h8000 : 16'h8001;
            2: begin
                r = $urandom_range(98, 102);
                return $urandom_range(1) ? 16'(r) : 16'(-r);
            end
            3, 4, 5, 6: return 16'($urandom_range(260) - 130);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.opcode      = ($urandom_range(9) == 0) ? OP_STOP : OP_MOVE;
        c.speed_one   = rand_speed();
        c.speed_two   = rand_speed();
        c.speed_three = rand_speed();
        c.speed_four  = rand_speed();
        return c;
    endfunction

    function automatic t_step_row mk_row(input logic bin, input logic [7:0] hdr,
                                         input logic [7:0] ftr, input t_op op,
                                         input logic [15:0] s1, input logic [15:0] s2,
                                         input logic [15:0] s3, input logic [15:0] s4,
                                         input logic [175:0] text);
        t_step_row r;
        r.binary          = bin;
        r.header          = hdr;
        r.footer          = ftr;
        r.cmd.opcode      = op;
        r.cmd.speed_one   = s1;
        r.cmd.speed_two   = s2;
        r.cmd.speed_three = s3;
        r.cmd.speed_four  = s4;
        r.text            = text;
        return r;
    endfunction

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch($sformatf("byte %h with no frame pending", o_res.out_byte));
            end else begin
                due_byte = frame_bytes_due.pop_front();
                if (o_res.out_byte !== due_byte.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                                              o_res.out_byte, due_byte.out_byte));
                if (o_res.frame_end !== due_byte.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              o_res.frame_end, due_byte.frame_end));
            end
        end
    end

    // watchdog: cycles with no transaction on any port
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[motor_command_framer_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd   = '0;
        i_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cfg_shadow = '0;

        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_STOP, 0, 0, 0, 0, STOP_TXT));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE, 0, 0, 0, 0,
                                   "1F0002F0003F0004F000\015\012"));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE,
                                   16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                   "1F1002F1003F1004F100\015\012"));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE,
                                   16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                   "1R1002R1003R1004R100\015\012"));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE,
                                   16'd100, -16'd100, 16'd101, -16'd101,
                                   "1F1002R1003F1004R100\015\012"));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE,
                                   16'd99, -16'd99, 16'd1, -16'd1,
                                   "1F0992R0993F0014R001\015\012"));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_MOVE,
                                   16'd10, -16'd10, 16'd55, -16'd7, '0));
        step_rows.push_back(mk_row(0, 8'h00, 8'h00, OP_STOP,
                                   16'h8000, 16'h7fff, 16'h1234, 16'hffff, STOP_TXT));
        step_rows.push_back(mk_row(1, 8'hff, 8'h00, OP_MOVE, 0, 0, 0, 0, '0));
        step_rows.push_back(mk_row(1, 8'hff, 8'h00, OP_MOVE,
                                   16'h7fff, 16'h8000, 16'h8001, 16'hffff, '0));
        step_rows.push_back(mk_row(1, 8'hff, 8'h00, OP_MOVE,
                                   16'h0001, 16'h0100, 16'hff00, 16'h1234, '0));
        step_rows.push_back(mk_row(1, 8'hff, 8'h00, OP_STOP,
                                   16'h7fff, 16'h7fff, 16'h8000, 16'h0001, STOP_TXT));
        step_rows.push_back(mk_row(1, 8'h00, 8'hff, OP_MOVE,
                                   16'h8000, 16'h8000, 16'h8000, 16'h8000, '0));
        step_rows.push_back(mk_row(1, 8'h00, 8'hff, OP_MOVE,
                                   16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, '0));
        step_rows.push_back(mk_row(1, 8'h00, 8'hff, OP_STOP,
                                   16'h8000, 16'h8000, 16'h8000, 16'h8000, STOP_TXT));
        step_rows.push_back(mk_row(1, 8'ha5, 8'h5a, OP_MOVE,
                                   16'h5555, 16'haaaa, 16'h00ff, 16'hff01, '0));
        step_rows.push_back(mk_row(0, 8'ha5, 8'h5a, OP_MOVE,
                                   16'haaaa, 16'h5555, 16'h0064, 16'hff9c, '0));
        step_rows.push_back(mk_row(0, 8'ha5, 8'h5a, OP_STOP,
                                   16'h5555, 16'haaaa, 0, 0, STOP_TXT));

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        snd_idle = 26;
        rcv_idle = 71;
        // writes past the last register must leave the settings alone
        cfg_write(REG_UNUSED, 32'hffff_ffff);

        foreach (step_rows[k]) begin
            if (step_rows[k].binary != cfg_shadow.binary_mode
                || step_rows[k].header != cfg_shadow.header_byte
                || step_rows[k].footer != cfg_shadow.footer_byte) begin
                wait_drained();
                cfg_write(REG_BINARY_MODE, {31'd0, step_rows[k].binary});
                cfg_write(REG_HEADER_BYTE, {24'd0, step_rows[k].header});
                cfg_write(REG_FOOTER_BYTE, {24'd0, step_rows[k].footer});
            end
            send_cmd(step_rows[k].cmd, step_rows[k].text);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            snd_idle = (ph < 2) ? 26 : (ph < 4) ? 71 : 0;
            rcv_idle = (ph < 2) ? 71 : (ph < 4) ? 26 : 0;
            case (ph)
                0, 3: begin
                    cfg_write(REG_BINARY_MODE, 32'd0);
                    cfg_write(REG_HEADER_BYTE, $urandom);
                end
                1: begin
                    cfg_write(REG_BINARY_MODE, 32'hffff_ffff);
                    cfg_write(REG_HEADER_BYTE, 32'h0000_0000);
                    cfg_write(REG_FOOTER_BYTE, 32'hffff_ffff);
                end
                4: begin
                    cfg_write(REG_BINARY_MODE, 32'd1);
                    cfg_write(REG_HEADER_BYTE, 32'h0000_00ff);
                    cfg_write(REG_FOOTER_BYTE, 32'h0000_0000);
                end
                default: begin
                    cfg_write(REG_BINARY_MODE, 32'd1);
                    cfg_write(REG_HEADER_BYTE, $urandom);
                    cfg_write(REG_FOOTER_BYTE, $urandom);
                end
            endcase
            cfg_write(REG_UNUSED, $urandom);
            for (int k = 0; k < PHASE_CMDS; k++) begin
                if (k == 25) wait_drained();
                send_cmd(rand_cmd(), '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && frame_bytes_due.size() == 0) begin
            $display("[motor_command_framer_top] OK");
        end else begin
            $display("[motor_command_framer_top] ERROR");
        end
        $finish;
    end

endmodule
